@@ hw/rtl/plb_pkg.sv @@
package plb_pkg;

  // Width of the request position field
  localparam int POS_W = 8;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Cell operation broadcast along the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/plb_cell.sv @@
module plb_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int CELL_IDX   = 0
) (
  input  logic                        clk,
  input  plb_pkg::cell_ctrl_t         ctrl,
  input  logic [ELEM_WIDTH-1:0]       ins_value,
  input  logic [ELEM_WIDTH-1:0]       left_data,
  input  logic [ELEM_WIDTH-1:0]       right_data,
  input  logic [plb_pkg::POS_W-1:0]   sel_pos,
  input  logic [plb_pkg::POS_W-1:0]   last_pos,
  output logic [ELEM_WIDTH-1:0]       data,
  output logic [ELEM_WIDTH-1:0]       rd_tap,
  output logic [ELEM_WIDTH-1:0]       last_tap
);
  import plb_pkg::*;

  localparam logic [POS_W-1:0] IDX_P = POS_W'(CELL_IDX);

  logic [ELEM_WIDTH-1:0] data_r;
  logic [ELEM_WIDTH-1:0] data_nxt;

  // Shift in from the left on insert, from the right on remove
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (IDX_P > ctrl.pos) begin
          data_nxt = left_data;
        end else if (IDX_P == ctrl.pos) begin
          data_nxt = ins_value;
        end
      end
      CELL_REMOVE: begin
        if (IDX_P >= ctrl.pos) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Taps are zero unless this cell is the one addressed
  assign data     = data_r;
  assign rd_tap   = (IDX_P == sel_pos)  ? data_r : '0;
  assign last_tap = (IDX_P == last_pos) ? data_r : '0;

endmodule

@@ hw/rtl/positional_list_buffer.sv @@
// Ordered list of up to DEPTH element words, head at position 0.
// Input channel (in_valid/in_ready): one request of req_type insert-before,
// remove-at or read-at, with a position and an element word. Insert or
// remove at a position at or beyond the count acts on the end of the list.
// Result channel (out_valid/out_ready): one result per request with status,
// the value read or removed, the count and the head and tail words.
// The request is taken into the row of cells and the status register, then
// calc_r loads the result register from the shifted row and out_valid rises.
// No request is accepted in the cycle after an accept; in that cycle the
// row of cells has shifted and the head and tail are taken from it.
// The cells shift the whole row by one place at once, so insert
// and remove cost the same as read.
// A stalled result holds in the output register; the next request is
// accepted as the result leaves, and is held off while it waits.
// Reset (rst_n low, synchronous) empties the list and holds off requests;
// stored words are not cleared, since only positions below the count are read.
module positional_list_buffer #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [plb_pkg::POS_W-1:0]      in_position,
  input  logic [ELEM_WIDTH-1:0]          in_element_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [ELEM_WIDTH-1:0]          out_read_value,
  output logic [$clog2(DEPTH+1)-1:0]     out_entry_count,
  output logic [ELEM_WIDTH-1:0]          out_first_value,
  output logic [ELEM_WIDTH-1:0]          out_last_value
);
  import plb_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  calc_r;
  logic [1:0]            status_r;
  logic [ELEM_WIDTH-1:0] rd_r;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [ELEM_WIDTH-1:0] out_read_r;
  logic [CNT_W-1:0]      out_count_r;
  logic [ELEM_WIDTH-1:0] out_first_r;
  logic [ELEM_WIDTH-1:0] out_last_r;

  logic                  in_fire;
  logic                  full, empty;
  logic [CMP_W-1:0]      pos_c, cnt_c;
  logic [POS_W-1:0]      ins_pos, rem_pos, sel_pos, last_pos;
  logic [1:0]            status_nxt;
  logic                  rd_en;
  cell_ctrl_t            ctrl;

  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_tap    [DEPTH];
  logic [ELEM_WIDTH-1:0] last_tap  [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_bus, last_bus;

  // Handshake: no accept in reset, during the result cycle or while a result is stuck
  assign in_ready = rst_n && !calc_r && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Request decode against the current count
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pos_c   = CMP_W'(in_position);
  assign cnt_c   = CMP_W'(cnt_r);
  assign ins_pos = (pos_c > cnt_c) ? POS_W'(cnt_r) : in_position;
  assign rem_pos = (pos_c >= cnt_c) ? POS_W'(cnt_r - CNT_W'(1)) : in_position;
  assign sel_pos = (in_req_type == REQ_REMOVE) ? rem_pos : in_position;
  assign last_pos = POS_W'(cnt_r - CNT_W'(1));

  always_comb begin
    status_nxt = ST_OK;
    rd_en      = 1'b0;
    ctrl.op    = CELL_HOLD;
    ctrl.pos   = ins_pos;
    cnt_nxt    = cnt_r;
    case (in_req_type)
      REQ_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        ctrl.pos = rem_pos;
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.op = CELL_REMOVE;
          rd_en   = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: status_nxt = ST_RANGE;
    endcase
    if (!in_fire) begin
      ctrl.op = CELL_HOLD;
      cnt_nxt = cnt_r;
    end
  end

  // Row of cells, each shifting with its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    plb_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .CELL_IDX   (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .ins_value  (in_element_value),
      .left_data  (left_d),
      .right_data (right_d),
      .sel_pos    (sel_pos),
      .last_pos   (last_pos),
      .data       (cell_data[g]),
      .rd_tap     (rd_tap[g]),
      .last_tap   (last_tap[g])
    );
  end

  // Taps are one-hot, so an OR picks the addressed cell
  always_comb begin
    rd_bus   = '0;
    last_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus   = rd_bus | rd_tap[i];
      last_bus = last_bus | last_tap[i];
    end
  end

  // Control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      calc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      calc_r <= in_fire;
      if (calc_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      rd_r     <= rd_en ? rd_bus : '0;
    end
    if (calc_r) begin
      out_status_r <= status_r;
      out_read_r   <= rd_r;
      out_count_r  <= cnt_r;
      out_first_r  <= empty ? '0 : cell_data[0];
      out_last_r   <= empty ? '0 : last_bus;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_r;
  assign out_entry_count = out_count_r;
  assign out_first_value = out_first_r;
  assign out_last_value  = out_last_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("list count beyond depth");

  a_no_accept_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    calc_r |-> !in_ready)
    else $error("request accepted during result cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req_type == REQ_INSERT && !full) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_count == '0) |-> (out_first_value == '0 && out_last_value == '0))
    else $error("empty list reports head or tail");

endmodule

@@ tb/positional_list_buffer_tb.sv @@
module positional_list_buffer_tb;
  import plb_pkg::*;

  localparam int DEPTH       = 16;
  localparam int ELEM_W      = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RANDOM_REQS = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 160;

  typedef struct {
    req_t              req;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] elem;
  } list_req_t;

  typedef struct {
    status_t           status;
    logic [ELEM_W-1:0] read_value;
    logic [CNT_W-1:0]  count;
    logic [ELEM_W-1:0] first;
    logic [ELEM_W-1:0] last;
  } list_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                    in_valid         = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_req_type      = '0;
  logic [POS_W-1:0]        in_position      = '0;
  logic [ELEM_W-1:0]       in_element_value = '0;
  logic                    out_valid;
  logic                    out_ready        = 1'b0;
  logic [1:0]              out_status;
  logic [ELEM_W-1:0]       out_read_value;
  logic [CNT_W-1:0]        out_entry_count;
  logic [ELEM_W-1:0]       out_first_value;
  logic [ELEM_W-1:0]       out_last_value;

  // Stimulus backlog, expected results and the shadow list
  list_req_t         req_backlog[$];
  list_result_t      due_results[$];
  logic [ELEM_W-1:0] shadow_list[$];

  int gen_count;
  int sent_count;
  int recv_count;
  int mismatches;
  int cycle_count;
  int tx_gap;
  int rx_wait;
  int hold_left;
  int hold_round;
  int op_count[4];
  int full_rejects;
  int empty_hits;
  int range_hits;
  int peak_count;

  positional_list_buffer #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_position      (in_position),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_read_value   (out_read_value),
    .out_entry_count  (out_entry_count),
    .out_first_value  (out_first_value),
    .out_last_value   (out_last_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the shadow list and return what the block should report
  function automatic list_result_t apply_request(list_req_t r);
    list_result_t res;
    int           n;
    int           p;
    n              = shadow_list.size();
    res.status     = ST_OK;
    res.read_value = '0;
    op_count[r.req]++;
    case (r.req)
      REQ_INSERT: begin
        if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          p = (r.pos > n) ? n : r.pos;
          shadow_list.insert(p, r.elem);
        end
      end
      REQ_REMOVE: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          p = (r.pos >= n) ? n - 1 : r.pos;
          res.read_value = shadow_list[p];
          shadow_list.delete(p);
        end
      end
      REQ_READ: begin
        if (n == 0) res.status = ST_EMPTY;
        else if (r.pos >= n) res.status = ST_RANGE;
        else res.read_value = shadow_list[r.pos];
      end
      default: res.status = ST_RANGE;
    endcase
    n         = shadow_list.size();
    res.count = n[CNT_W-1:0];
    res.first = (n != 0) ? shadow_list[0] : '0;
    res.last  = (n != 0) ? shadow_list[n-1] : '0;
    if (res.status == ST_FULL) full_rejects++;
    if (res.status == ST_EMPTY) empty_hits++;
    if (res.status == ST_RANGE) range_hits++;
    if (n > peak_count) peak_count = n;
    return res;
  endfunction

  // Queue a request and track the count it leaves behind, for position choice
  task automatic add_req(req_t req, int pos, logic [ELEM_W-1:0] elem);
    list_req_t r;
    r.req  = req;
    r.pos  = pos[POS_W-1:0];
    r.elem = elem;
    req_backlog.push_back(r);
    if (req == REQ_INSERT && gen_count < DEPTH) gen_count++;
    if (req == REQ_REMOVE && gen_count > 0) gen_count--;
  endtask

  function automatic logic [ELEM_W-1:0] pick_elem();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic int pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, gen_count + 1);
    if (r < 82) return (gen_count > 0) ? gen_count - 1 : 0;
    if (r < 88) return gen_count;
    return $urandom_range(0, 255);
  endfunction

  // Random requests in stretches biased toward filling, draining or mixing
  task automatic build_random();
    int   mode;
    int   r;
    req_t req;
    mode = 2;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 60 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (mode)
        0:       req = (r < 65) ? REQ_INSERT : (r < 83) ? REQ_REMOVE
                     : (r < 97) ? REQ_READ : REQ_NONE;
        1:       req = (r < 20) ? REQ_INSERT : (r < 82) ? REQ_REMOVE
                     : (r < 97) ? REQ_READ : REQ_NONE;
        default: req = (r < 38) ? REQ_INSERT : (r < 70) ? REQ_REMOVE
                     : (r < 97) ? REQ_READ : REQ_NONE;
      endcase
      add_req(req, pick_pos(), pick_elem());
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    gen_count = 0;
    // empty list: read, remove and an unknown request
    add_req(REQ_READ, 0, 32'h1234_5678);
    add_req(REQ_REMOVE, 0, 32'h0);
    add_req(REQ_NONE, 255, 32'hFFFF_FFFF);
    // append on empty, insert at head, in the middle and past the end
    add_req(REQ_INSERT, 255, 32'h0000_0000);
    add_req(REQ_INSERT, 0, 32'hFFFF_FFFF);
    add_req(REQ_INSERT, 1, 32'hA5A5_A5A5);
    add_req(REQ_INSERT, 200, 32'h5A5A_5A5A);
    // reads: head, tail, at the count, far out of range
    add_req(REQ_READ, 0, 32'h0);
    add_req(REQ_READ, 3, 32'h0);
    add_req(REQ_READ, 4, 32'h0);
    add_req(REQ_READ, 255, 32'h0);
    add_req(REQ_NONE, 1, 32'h0);
    // remove past the end (pops the last), dequeue, remove at the tail position
    add_req(REQ_REMOVE, 255, 32'h0);
    add_req(REQ_REMOVE, 0, 32'h0);
    add_req(REQ_REMOVE, 1, 32'h0);
    // fill up, then hit a full list
    for (int i = 0; i < DEPTH - 1; i++) add_req(REQ_INSERT, (i * 5) % (gen_count + 2), $urandom);
    add_req(REQ_INSERT, 0, 32'hDEAD_BEEF);
    add_req(REQ_READ, DEPTH - 1, 32'h0);
    add_req(REQ_REMOVE, DEPTH / 2, 32'h0);
    build_random();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("requests: %0d insert, %0d remove, %0d read, %0d unknown; %0d results checked",
             op_count[REQ_INSERT], op_count[REQ_REMOVE], op_count[REQ_READ],
             op_count[REQ_NONE], recv_count);
    $display("full rejects %0d, empty hits %0d, out of range %0d, peak count %0d, mismatches %0d",
             full_rejects, empty_hits, range_hits, peak_count, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("positional_list_buffer_tb OK");
    end else begin
      $display("positional_list_buffer_tb NOT OK");
    end
    $finish;
  end

  // Driver: predicts on accept, then offers the next request after a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      tx_gap     <= 0;
      sent_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        list_req_t r;
        r.req  = req_t'(in_req_type);
        r.pos  = in_position;
        r.elem = in_element_value;
        due_results.push_back(apply_request(r));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (req_backlog.size() != 0) begin
          list_req_t nxt;
          nxt = req_backlog.pop_front();
          in_valid         <= 1'b1;
          in_req_type      <= nxt.req;
          in_position      <= nxt.pos;
          in_element_value <= nxt.elem;
          // every third stretch of 100 requests runs back to back
          tx_gap <= ((sent_count / 100) % 3 == 0) ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, twice, so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_round <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((hold_round == 0 && sent_count >= 350) ||
                 (hold_round == 1 && sent_count >= 1100)) begin
      hold_left  <= HOLD_CYCLES;
      hold_round <= hold_round + 1;
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    int w;
    list_result_t exp_res;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      rx_wait    <= 0;
      recv_count <= 0;
      mismatches <= 0;
    end else begin
      w = rx_wait;
      if (out_valid && out_ready) begin
        recv_count <= recv_count + 1;
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status %0d read %h count %0d first %h last %h",
                     out_status, out_read_value, out_entry_count,
                     out_first_value, out_last_value);
          mismatches <= mismatches + 1;
        end else begin
          exp_res = due_results.pop_front();
          if (out_status !== exp_res.status || out_read_value !== exp_res.read_value ||
              out_entry_count !== exp_res.count || out_first_value !== exp_res.first ||
              out_last_value !== exp_res.last) begin
            if (mismatches < 10) begin
              $display("mismatch on result %0d", recv_count);
              $display("  expected: status %0d read %h count %0d first %h last %h",
                       exp_res.status, exp_res.read_value, exp_res.count,
                       exp_res.first, exp_res.last);
              $display("  actual:   status %0d read %h count %0d first %h last %h",
                       out_status, out_read_value, out_entry_count,
                       out_first_value, out_last_value);
            end
            mismatches <= mismatches + 1;
          end
        end
        // some stretches never stall
        w = ((recv_count / 130) % 3 == 1) ? 0 : $urandom_range(0, 19);
      end else if (w > 0) begin
        w = w - 1;
      end
      rx_wait   <= w;
      out_ready <= (w == 0) && (hold_left == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("positional_list_buffer_tb NOT OK");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
